### sv/dxtdec_pkg.sv
// Shared types, constants and arithmetic helpers for the DXT1/DXT5 block decoder.
// No dependencies; imported by every decoder module and the checker.
`default_nettype none
package dxtdec_pkg;

  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 160;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [12:0] DIM_RESET = 13'd4096;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
    logic [9:0]  row;
    logic [9:0]  col;
  } dxtdec_in_t;

  typedef struct packed {
    logic        dxt5;
    logic [12:0] width;
    logic [12:0] height;
  } dxtdec_cfg_t;

  typedef struct packed {
    logic        four_mode;
    logic        dxt5;
    logic        a_eight;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [7:0]  r0;
    logic [7:0]  g0;
    logic [7:0]  b0;
    logic [7:0]  r1;
    logic [7:0]  g1;
    logic [7:0]  b1;
    logic [31:0] codes;
    logic [47:0] acodes;
    logic [11:0] x0;
    logic [11:0] y0;
    logic [3:0]  col_ok;
    logic [3:0]  row_ok;
  } dxtdec_endp_t;

  typedef struct packed {
    logic [3:0][23:0] pal;
    logic [7:0][7:0]  alpha;
    logic [31:0]      codes;
    logic [47:0]      acodes;
    logic [11:0]      x0;
    logic [11:0]      y0;
    logic [3:0]       col_ok;
    logic [3:0]       row_ok;
  } dxtdec_pal_t;

  typedef struct packed {
    logic             last;
    logic [3:0]       mask;
    logic [3:0][31:0] pix;
    logic [11:0]      y;
    logic [11:0]      x;
  } dxtdec_row_t;

  // t = v*255+16, (t/32 + t)/32
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [12:0] t;
    logic [13:0] s;
    t = 13'(v) * 13'd255 + 13'd16;
    s = 14'(t >> 5) + 14'(t);
    return s[12:5];
  endfunction

  // t = v*255+32, (t/64 + t)/64
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] t;
    logic [13:0] s;
    t = 14'(v) * 14'd255 + 14'd32;
    s = (t >> 6) + t;
    return s[13:6];
  endfunction

  // exact for n < 768
  function automatic logic [7:0] div3(input logic [9:0] n);
    logic [20:0] p;
    p = 21'(n) * 21'd683;
    return p[18:11];
  endfunction

  // exact for n < 1792
  function automatic logic [7:0] div7(input logic [10:0] n);
    logic [24:0] p;
    p = 25'(n) * 25'd2341;
    return p[21:14];
  endfunction

  // exact for n < 1280
  function automatic logic [7:0] div5(input logic [10:0] n);
    logic [24:0] p;
    p = 25'(n) * 25'd3277;
    return p[21:14];
  endfunction

endpackage
`default_nettype wire

### sv/dxtdec_endpoints.sv
// Stage 1: splits the block, expands RGB565 endpoints, precomputes edge masks.
// Depends on dxtdec_pkg.
`default_nettype none
module dxtdec_endpoints import dxtdec_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire dxtdec_cfg_t  cfg_i,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire dxtdec_in_t   data_i,
  output logic              valid_o,
  input  wire logic         ready_i,
  output dxtdec_endp_t      data_o
);

  logic         valid_q;
  dxtdec_endp_t data_q, data_d;

  logic [63:0] colour;
  logic [15:0] c0, c1;

  always_comb begin
    colour = cfg_i.dxt5 ? data_i.high : data_i.low;
    c0 = colour[15:0];
    c1 = colour[31:16];
    data_d.dxt5      = cfg_i.dxt5;
    data_d.four_mode = cfg_i.dxt5 || (c0 > c1);
    data_d.a0        = data_i.low[7:0];
    data_d.a1        = data_i.low[15:8];
    data_d.a_eight   = data_i.low[7:0] > data_i.low[15:8];
    data_d.r0        = expand5(c0[15:11]);
    data_d.g0        = expand6(c0[10:5]);
    data_d.b0        = expand5(c0[4:0]);
    data_d.r1        = expand5(c1[15:11]);
    data_d.g1        = expand6(c1[10:5]);
    data_d.b1        = expand5(c1[4:0]);
    data_d.codes     = colour[63:32];
    data_d.acodes    = data_i.low[63:16];
    data_d.x0        = {data_i.col, 2'b00};
    data_d.y0        = {data_i.row, 2'b00};
    for (int i = 0; i < 4; i++) begin
      data_d.col_ok[i] = ({1'b0, data_d.x0} + 13'(i)) < cfg_i.width;
      data_d.row_ok[i] = ({1'b0, data_d.y0} + 13'(i)) < cfg_i.height;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

### sv/dxtdec_palette.sv
// Stage 2: builds the four-entry colour palette and the eight-entry alpha table.
// Depends on dxtdec_pkg.
`default_nettype none
module dxtdec_palette import dxtdec_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire dxtdec_endp_t  data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output dxtdec_pal_t        data_o
);

  logic        valid_q;
  dxtdec_pal_t data_q, data_d;

  logic [7:0][7:0] al8, al6;
  logic [7:0]      r2, g2, b2, r3, g3, b3;

  always_comb begin
    logic [10:0] num8;
    logic [10:0] num6;
    al8 = '0;
    al6 = '0;
    for (int k = 2; k < 8; k++) begin
      num8 = 11'(8 - k) * 11'(data_i.a0) + 11'(k - 1) * 11'(data_i.a1);
      al8[k] = div7(num8);
    end
    for (int k = 2; k < 6; k++) begin
      num6 = 11'(6 - k) * 11'(data_i.a0) + 11'(k - 1) * 11'(data_i.a1);
      al6[k] = div5(num6);
    end
    al8[0] = data_i.a0;
    al8[1] = data_i.a1;
    al6[0] = data_i.a0;
    al6[1] = data_i.a1;
    al6[6] = 8'd0;
    al6[7] = 8'd255;

    if (data_i.four_mode) begin
      r2 = div3(10'(data_i.r0) + 10'(data_i.r0) + 10'(data_i.r1));
      g2 = div3(10'(data_i.g0) + 10'(data_i.g0) + 10'(data_i.g1));
      b2 = div3(10'(data_i.b0) + 10'(data_i.b0) + 10'(data_i.b1));
      r3 = div3(10'(data_i.r0) + 10'(data_i.r1) + 10'(data_i.r1));
      g3 = div3(10'(data_i.g0) + 10'(data_i.g1) + 10'(data_i.g1));
      b3 = div3(10'(data_i.b0) + 10'(data_i.b1) + 10'(data_i.b1));
    end else begin
      r2 = 8'((9'(data_i.r0) + 9'(data_i.r1)) >> 1);
      g2 = 8'((9'(data_i.g0) + 9'(data_i.g1)) >> 1);
      b2 = 8'((9'(data_i.b0) + 9'(data_i.b1)) >> 1);
      r3 = 8'd0;
      g3 = 8'd0;
      b3 = 8'd0;
    end

    data_d.pal[0] = {data_i.r0, data_i.g0, data_i.b0};
    data_d.pal[1] = {data_i.r1, data_i.g1, data_i.b1};
    data_d.pal[2] = {r2, g2, b2};
    data_d.pal[3] = {r3, g3, b3};
    if (!data_i.dxt5) begin
      data_d.alpha = {8{8'd255}};
    end else if (data_i.a_eight) begin
      data_d.alpha = al8;
    end else begin
      data_d.alpha = al6;
    end
    data_d.codes  = data_i.codes;
    data_d.acodes = data_i.acodes;
    data_d.x0     = data_i.x0;
    data_d.y0     = data_i.y0;
    data_d.col_ok = data_i.col_ok;
    data_d.row_ok = data_i.row_ok;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

### sv/dxtdec_rows.sv
// Stage 3: holds one decoded block and emits its four pixel rows into an output register.
// Depends on dxtdec_pkg.
`default_nettype none
module dxtdec_rows import dxtdec_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire dxtdec_pal_t  data_i,
  output logic              valid_o,
  input  wire logic         ready_i,
  output dxtdec_row_t       data_o
);

  logic        blk_valid_q;
  dxtdec_pal_t blk_q;
  logic [1:0]  cnt_q;
  logic        out_valid_q;
  dxtdec_row_t out_q, row_d;

  logic        load, done, take;
  logic [7:0]  row_codes;
  logic [11:0] row_acodes;

  assign load    = blk_valid_q && (!out_valid_q || ready_i);
  assign done    = load && (cnt_q == 2'd3);
  assign ready_o = !blk_valid_q || done;
  assign take    = valid_i && ready_o;

  always_comb begin
    logic [1:0] idx;
    logic [2:0] acode;
    row_codes  = blk_q.codes[{cnt_q, 3'b000} +: 8];
    row_acodes = blk_q.acodes[6'(cnt_q) * 6'd12 +: 12];
    for (int i = 0; i < 4; i++) begin
      idx   = row_codes[2*i +: 2];
      acode = row_acodes[3*i +: 3];
      row_d.pix[i] = {blk_q.alpha[acode], blk_q.pal[idx]};
    end
    row_d.x    = blk_q.x0;
    row_d.y    = blk_q.y0 + 12'(cnt_q);
    row_d.mask = blk_q.col_ok & {4{blk_q.row_ok[cnt_q]}};
    row_d.last = (cnt_q == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        blk_valid_q <= 1'b1;
      end else if (done) begin
        blk_valid_q <= 1'b0;
      end
      if (load) begin
        cnt_q <= cnt_q + 2'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      blk_q <= data_i;
    end
    if (load) begin
      out_q <= row_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

### sv/dxt1_dxt5_block_decoder.sv
// DXT1/DXT5 block decoder: one compressed 4x4 block in, four pixel rows out.
// Throughput: one row per cycle unless stalled by m_axis_tready; the row emitter takes
// a new block as it loads the last row. Three register stages plus the output register;
// stages 1 and 2 take a block every cycle unless stalled from downstream.
// Reset: format DXT1, width and height 4096, all stages empty; no clearing pass.
// Depends on dxtdec_pkg, dxtdec_endpoints, dxtdec_palette, dxtdec_rows.
`default_nettype none
module dxt1_dxt5_block_decoder import dxtdec_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // block_col[9:0], block_row[19:10], block_low[83:20], block_high[147:84], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // row_x[11:0], row_y[23:12], pixel_a..pixel_d[151:24], write_mask[155:152], zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tlast,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int DimW = $clog2(MAX_DIM + 1);
  localparam int CmpW = (DimW > 13) ? DimW : 13;
  localparam logic [CmpW-1:0] DimMax = CmpW'(MAX_DIM);

  logic        format_q;
  logic [12:0] width_q, height_q;
  logic [CmpW-1:0] w_ext, h_ext, w_sat, h_sat;
  dxtdec_cfg_t cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= 1'b0;
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FORMAT: format_q <= cfg_data_i[0];
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_ext = CmpW'(width_q);
  assign h_ext = CmpW'(height_q);
  assign w_sat = (w_ext > DimMax) ? DimMax : w_ext;
  assign h_sat = (h_ext > DimMax) ? DimMax : h_ext;

  assign cfg.dxt5   = format_q;
  assign cfg.width  = w_sat[12:0];
  assign cfg.height = h_sat[12:0];

  dxtdec_in_t   in_item;
  logic         e_valid, e_ready, p_valid, p_ready;
  dxtdec_endp_t e_data;
  dxtdec_pal_t  p_data;
  dxtdec_row_t  row;

  assign in_item = dxtdec_in_t'(s_axis_tdata[$bits(dxtdec_in_t)-1:0]);

  dxtdec_endpoints u_endpoints (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (in_item),
    .valid_o (e_valid),
    .ready_i (e_ready),
    .data_o  (e_data)
  );

  dxtdec_palette u_palette (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e_valid),
    .ready_o (e_ready),
    .data_i  (e_data),
    .valid_o (p_valid),
    .ready_i (p_ready),
    .data_o  (p_data)
  );

  dxtdec_rows u_rows (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_valid),
    .ready_o (p_ready),
    .data_i  (p_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (row)
  );

  assign m_axis_tdata = {4'b0000, row.mask, row.pix, row.y, row.x};
  assign m_axis_tlast = row.last;

endmodule
`default_nettype wire

### sv/dxtdec_checker.sv
// Port-level checker for the DXT1/DXT5 block decoder, bound to the top level.
// Depends on dxtdec_pkg and dxt1_dxt5_block_decoder.
`default_nettype none
module dxtdec_checker import dxtdec_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tlast
);

  logic        in_acc, out_acc, out_done;
  logic [1:0]  row_q;
  logic [3:0]  open_q;
  logic [11:0] px_q, py_q;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign out_done = out_acc && m_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= 2'd0;
      open_q <= 4'd0;
      px_q   <= 12'd0;
      py_q   <= 12'd0;
    end else begin
      if (out_acc) begin
        row_q <= row_q + 2'd1;
        px_q  <= m_axis_tdata[11:0];
        py_q  <= m_axis_tdata[23:12];
      end
      open_q <= open_q + 4'(in_acc) - 4'(out_done);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  a_last_fourth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (m_axis_tlast == (row_q == 2'd3)))
    else $error("tlast not on every fourth row");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (row_q != 2'd0) |->
      (m_axis_tdata[11:0] == px_q) && (m_axis_tdata[23:12] == py_q + 12'd1))
    else $error("row coordinates do not step within a block");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (open_q != 4'd0))
    else $error("output row without an open block");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 4'd4)
    else $error("more blocks in flight than pipeline stages");

endmodule

bind dxt1_dxt5_block_decoder dxtdec_checker u_dxtdec_checker (.*);
`default_nettype wire
